// ===== rtl/tagged_event_stream_parser_assert.svh =====
// Assertion macros for the tagged event stream parser
`ifndef TAGGED_EVENT_STREAM_PARSER_ASSERT_SVH
`define TAGGED_EVENT_STREAM_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TESP_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TESP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TESP_ASSERT_IMPL(label, clk, rst_n, prop)
`define TESP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/tesp_pkg.sv =====
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared types and constants of the tagged event stream parser.
// ----------------------------------------------------------------------------
package tesp_pkg;
    typedef enum logic [3:0] {
        ST_HPRE, ST_HBODY, ST_DPRE, ST_ID, ST_FIXED, ST_LEN, ST_PAYLOAD, ST_DONE, ST_HALT
    } t_stage;

    localparam logic [3:0] K_END = 4'd0, K_HEADER = 4'd1, K_CHANNEL = 4'd2,
        K_PATTERN = 4'd3, K_TEMPO = 4'd4, K_NOTE = 4'd5, K_REJECT = 4'd6,
        K_SHORT = 4'd7, K_BAD_MAGIC = 4'd8, K_BAD_HSIZE = 4'd9, K_ZERO_TPQ = 4'd10,
        K_NO_DATA = 4'd11, K_DATA_LONG = 4'd12, K_TRUNC = 4'd13, K_LEN_LONG = 4'd14;

    localparam logic [7:0] ID_CHANNEL = 8'd64, ID_PATTERN = 8'd65, ID_TEMPO_BPM = 8'd66,
        ID_TEMPO_MILLI = 8'd156, ID_TEXT0 = 8'd192, ID_TEXT1 = 8'd193,
        ID_TEXT2 = 8'd194, ID_TEXT3 = 8'd199, ID_NOTES = 8'd224;

    localparam logic [19:0] TEMPO_RESET = 20'd120000;
    localparam logic [31:0] TEMPO_MIN = 32'd20000, TEMPO_MAX = 32'd999000;

    // one result transaction
    typedef struct packed {
        logic [3:0]  kind;
        logic        done;
        logic [15:0] pattern;
        logic [15:0] channel;
        logic [31:0] position;
        logic [31:0] duration;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [19:0] tempo;
        logic [15:0] tpq;
        logic [31:0] read_cnt;
        logic [31:0] und_cnt;
    } t_result;

    function automatic logic [7:0] head_magic(input logic [1:0] i);
        case (i)
            2'd0: head_magic = 8'h46;
            2'd1: head_magic = 8'h4C;
            2'd2: head_magic = 8'h68;
            default: head_magic = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] data_magic(input logic [1:0] i);
        case (i)
            2'd0: data_magic = 8'h46;
            2'd1: data_magic = 8'h4C;
            2'd2: data_magic = 8'h64;
            default: data_magic = 8'h74;
        endcase
    endfunction
endpackage

// ===== rtl/tesp_core.sv =====
// ----------------------------------------------------------------------------
// tesp_core
// Parser state and the single-pass step logic for one input byte.
// ----------------------------------------------------------------------------
module tesp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_eof,
    output logic               o_res_valid,
    output tesp_pkg::t_result  o_res,
    output tesp_pkg::t_stage   o_stage
);
    tesp_pkg::t_stage r_stage, n_stage;
    logic [4:0]  r_idx, n_idx;
    logic [31:0] r_hleft, n_hleft, r_bleft, n_bleft, r_acc, n_acc;
    logic [7:0]  r_id, n_id;
    logic [5:0]  r_shift, n_shift;
    logic [34:0] r_pleft, n_pleft;
    logic        r_notes, n_notes;
    logic [63:0] r_nr0, n_nr0, r_nr1, n_nr1;
    logic [15:0] r_chan, n_chan, r_pat, n_pat, r_res, n_res, r_ccnt, n_ccnt;
    logic [19:0] r_tempo, n_tempo;
    logic [31:0] r_rd, n_rd, r_und, n_und;

    logic        emit, fail, complete, understood, done;
    logic [3:0]  kind;
    logic [15:0] ch;
    logic [31:0] pos, dur;
    logic [6:0]  pit, vel;
    logic [31:0] bl, v, need, nch_lim;
    logic [34:0] pl;
    logic [7:0]  p8, v8;
    logic [4:0]  o;

    // divisible by three: 4 is 1 mod 3, so sum the base-4 digits and fold once
    function automatic logic div_by_3(input logic [31:0] x);
        logic [5:0] s;
        logic [3:0] t;
        s = '0;
        for (int k = 0; k < 16; k++) s = s + 6'(x[2*k +: 2]);
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        div_by_3 = (t == 4'd0) || (t == 4'd3) || (t == 4'd6) || (t == 4'd9);
    endfunction

    // step logic for one byte
    always_comb begin
        n_stage = r_stage; n_idx = r_idx; n_hleft = r_hleft; n_bleft = r_bleft;
        n_acc = r_acc; n_id = r_id; n_shift = r_shift; n_pleft = r_pleft;
        n_notes = r_notes; n_nr0 = r_nr0; n_nr1 = r_nr1; n_chan = r_chan;
        n_pat = r_pat; n_res = r_res; n_ccnt = r_ccnt; n_tempo = r_tempo;
        n_rd = r_rd; n_und = r_und;
        emit = 1'b0; fail = 1'b0; complete = 1'b0; understood = 1'b0; done = 1'b0;
        kind = tesp_pkg::K_END; ch = r_chan; pos = '0; dur = '0; pit = '0; vel = '0;
        bl = r_bleft; v = '0; need = '0; pl = '0; p8 = '0; v8 = '0; o = '0;
        nch_lim = '0;
        case (r_stage)
            tesp_pkg::ST_HPRE: begin
                if (r_idx < 5'd7 && i_eof) begin
                    fail = 1'b1; kind = tesp_pkg::K_SHORT;
                end else if (r_idx < 5'd4) begin
                    if (i_byte != tesp_pkg::head_magic(r_idx[1:0])) begin
                        fail = 1'b1; kind = tesp_pkg::K_BAD_MAGIC;
                    end else begin
                        if (r_idx == 5'd0) n_acc = '0;
                        n_idx = r_idx + 5'd1;
                    end
                end else begin
                    n_acc = r_acc | ({24'd0, i_byte} << {r_idx[1:0], 3'd0});
                    n_idx = r_idx + 5'd1;
                    if (r_idx == 5'd7) begin
                        n_hleft = n_acc;
                        if (n_acc < 32'd6 || i_eof) begin
                            fail = 1'b1; kind = tesp_pkg::K_BAD_HSIZE;
                        end else begin
                            n_idx = '0; n_stage = tesp_pkg::ST_HBODY;
                        end
                    end
                end
            end
            tesp_pkg::ST_HBODY: begin
                n_hleft = r_hleft - 32'd1;
                case (r_idx)
                    5'd2: n_ccnt = {8'd0, i_byte};
                    5'd3: n_ccnt = {i_byte, r_ccnt[7:0]};
                    5'd4: n_res = {8'd0, i_byte};
                    5'd5: n_res = {i_byte, r_res[7:0]};
                    default: ;
                endcase
                if (r_idx < 5'd6) n_idx = r_idx + 5'd1;
                if (n_hleft == '0) begin
                    if (n_res == '0) begin
                        fail = 1'b1; kind = tesp_pkg::K_ZERO_TPQ;
                    end else if (i_eof) begin
                        fail = 1'b1; kind = tesp_pkg::K_NO_DATA;
                    end else begin
                        n_idx = '0; n_stage = tesp_pkg::ST_DPRE;
                        emit = 1'b1; kind = tesp_pkg::K_HEADER; ch = n_ccnt;
                    end
                end else if (i_eof) begin
                    fail = 1'b1; kind = tesp_pkg::K_BAD_HSIZE;
                end
            end
            tesp_pkg::ST_DPRE: begin
                if (r_idx < 5'd7 && i_eof) begin
                    fail = 1'b1; kind = tesp_pkg::K_NO_DATA;
                end else if (r_idx < 5'd4) begin
                    if (i_byte != tesp_pkg::data_magic(r_idx[1:0])) begin
                        fail = 1'b1; kind = tesp_pkg::K_NO_DATA;
                    end else begin
                        if (r_idx == 5'd0) n_acc = '0;
                        n_idx = r_idx + 5'd1;
                    end
                end else begin
                    n_acc = r_acc | ({24'd0, i_byte} << {r_idx[1:0], 3'd0});
                    n_idx = r_idx + 5'd1;
                    if (r_idx == 5'd7) begin
                        n_bleft = n_acc; n_idx = '0;
                        if (n_acc == '0) begin
                            n_stage = tesp_pkg::ST_DONE; emit = 1'b1; done = 1'b1;
                        end else if (i_eof) begin
                            fail = 1'b1; kind = tesp_pkg::K_DATA_LONG;
                        end else begin
                            n_stage = tesp_pkg::ST_ID;
                        end
                    end
                end
            end
            tesp_pkg::ST_ID, tesp_pkg::ST_FIXED, tesp_pkg::ST_LEN,
            tesp_pkg::ST_PAYLOAD: begin
                if (r_bleft != '0) bl = r_bleft - 32'd1;
                n_bleft = bl;
                if (i_eof && bl != '0) begin
                    fail = 1'b1; kind = tesp_pkg::K_DATA_LONG;
                end else if (r_stage == tesp_pkg::ST_ID) begin
                    need = (i_byte < 8'd64) ? 32'd1 : (i_byte < 8'd128) ? 32'd2 :
                           (i_byte < 8'd192) ? 32'd4 : 32'd0;
                    n_id = i_byte;
                    if (r_rd != '1) n_rd = r_rd + 32'd1;
                    if (need != '0) begin
                        if (bl < need) begin
                            fail = 1'b1; kind = tesp_pkg::K_TRUNC;
                        end else begin
                            n_acc = '0; n_idx = '0; n_pleft = {3'd0, need};
                            n_stage = tesp_pkg::ST_FIXED;
                        end
                    end else if (bl == '0) begin
                        fail = 1'b1; kind = tesp_pkg::K_TRUNC;
                    end else begin
                        n_pleft = '0; n_shift = '0; n_stage = tesp_pkg::ST_LEN;
                    end
                end else if (r_stage == tesp_pkg::ST_FIXED) begin
                    v = r_acc | ({24'd0, i_byte} << {r_idx[1:0], 3'd0});
                    n_acc = v;
                    n_idx = r_idx + 5'd1;
                    n_pleft = r_pleft - 35'd1;
                    if (n_pleft == '0) begin
                        complete = 1'b1;
                        if (r_id == tesp_pkg::ID_CHANNEL) begin
                            n_chan = v[15:0]; understood = 1'b1; emit = 1'b1;
                            kind = tesp_pkg::K_CHANNEL;
                        end else if (r_id == tesp_pkg::ID_PATTERN) begin
                            n_pat = v[15:0]; understood = 1'b1; emit = 1'b1;
                            kind = tesp_pkg::K_PATTERN;
                        end else if (r_id == tesp_pkg::ID_TEMPO_BPM && v >= 32'd20
                                     && v <= 32'd999) begin
                            n_tempo = 20'(v[9:0] * 20'd1000); understood = 1'b1;
                            emit = 1'b1; kind = tesp_pkg::K_TEMPO;
                        end else if (r_id == tesp_pkg::ID_TEMPO_MILLI
                                     && v >= tesp_pkg::TEMPO_MIN
                                     && v <= tesp_pkg::TEMPO_MAX) begin
                            n_tempo = v[19:0]; understood = 1'b1; emit = 1'b1;
                            kind = tesp_pkg::K_TEMPO;
                        end
                        ch = n_chan;
                    end
                end else if (r_stage == tesp_pkg::ST_LEN) begin
                    pl = r_pleft;
                    if (r_shift < 6'd35)
                        pl = r_pleft | (35'(i_byte[6:0]) << r_shift[4:0]);
                    n_pleft = pl;
                    if (i_byte[7]) begin
                        n_shift = r_shift + 6'd7;
                        if (n_shift > 6'd28) begin
                            fail = 1'b1; kind = tesp_pkg::K_LEN_LONG;
                        end else if (bl == '0) begin
                            fail = 1'b1; kind = tesp_pkg::K_TRUNC;
                        end
                    end else if (pl > {3'd0, bl}) begin
                        fail = 1'b1; kind = tesp_pkg::K_TRUNC;
                    end else begin
                        n_notes = 1'b0; n_idx = '0;
                        if (r_id == tesp_pkg::ID_NOTES) begin
                            // record multiple: divisible by 8 and by 3; fits 32 bits
                            if (pl[2:0] != 3'd0 || !div_by_3(pl[31:0])) begin
                                emit = 1'b1; kind = tesp_pkg::K_REJECT;
                            end else begin
                                n_notes = 1'b1;
                            end
                        end
                        if (pl == '0) complete = 1'b1;
                        else n_stage = tesp_pkg::ST_PAYLOAD;
                    end
                end else begin
                    if (r_notes) begin
                        o = r_idx;
                        if (o == 5'd0) begin
                            n_nr0 = '0; n_nr1 = '0;
                        end
                        if (o < 5'd4)
                            n_nr0 = n_nr0 | (64'(i_byte) << {o[1:0], 3'd0});
                        else if (o >= 5'd8 && o < 5'd12)
                            n_nr0 = n_nr0 | (64'(i_byte) << {1'b1, o[1:0], 3'd0});
                        else if (o == 5'd6)
                            n_nr1 = n_nr1 | 64'(i_byte);
                        else if (o == 5'd7)
                            n_nr1 = n_nr1 | (64'(i_byte) << 8);
                        else if (o == 5'd12)
                            n_nr1 = n_nr1 | (64'(i_byte) << 16);
                        else if (o == 5'd21)
                            n_nr1 = n_nr1 | (64'(i_byte) << 24);
                        o = o + 5'd1;
                        if (o >= 5'd24) begin
                            nch_lim = (r_ccnt == '0) ? 32'd256 : 32'(r_ccnt) + 32'd1;
                            o = '0;
                            if (n_nr0[63:32] != '0 && 32'(n_nr1[15:0]) < nch_lim) begin
                                p8 = n_nr1[23:16]; v8 = n_nr1[31:24];
                                emit = 1'b1; kind = tesp_pkg::K_NOTE;
                                ch = n_nr1[15:0]; pos = n_nr0[31:0];
                                dur = n_nr0[63:32];
                                pit = p8[7] ? 7'd127 : p8[6:0];
                                vel = v8[7] ? 7'd127 : (v8 == '0 ? 7'd1 : v8[6:0]);
                            end
                        end
                        n_idx = o;
                    end
                    n_pleft = r_pleft - 35'd1;
                    if (n_pleft == '0) complete = 1'b1;
                end
                if (!fail && complete) begin
                    if (r_id == tesp_pkg::ID_TEXT0 || r_id == tesp_pkg::ID_TEXT1 ||
                        r_id == tesp_pkg::ID_TEXT2 || r_id == tesp_pkg::ID_TEXT3 ||
                        (r_id == tesp_pkg::ID_NOTES && n_notes))
                        understood = 1'b1;
                    if (understood && r_und != '1) n_und = r_und + 32'd1;
                    n_stage = tesp_pkg::ST_ID;
                    if (bl == '0) begin
                        n_stage = tesp_pkg::ST_DONE; emit = 1'b1; done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (fail) begin
            n_stage = tesp_pkg::ST_HALT; emit = 1'b1; done = 1'b0;
            ch = n_chan; pos = '0; dur = '0; pit = '0; vel = '0;
        end
    end

    // result fields
    always_comb begin
        o_res_valid = emit;
        o_res.kind = kind; o_res.done = done; o_res.pattern = n_pat;
        o_res.channel = ch; o_res.position = pos; o_res.duration = dur;
        o_res.pitch = pit; o_res.velocity = vel; o_res.tempo = n_tempo;
        o_res.tpq = n_res; o_res.read_cnt = n_rd; o_res.und_cnt = n_und;
        o_stage = r_stage;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= tesp_pkg::ST_HPRE; r_idx <= '0; r_hleft <= '0; r_bleft <= '0;
            r_acc <= '0; r_id <= '0; r_shift <= '0; r_pleft <= '0; r_notes <= 1'b0;
            r_nr0 <= '0; r_nr1 <= '0; r_chan <= '0; r_pat <= '0;
            r_tempo <= tesp_pkg::TEMPO_RESET; r_res <= '0; r_ccnt <= '0;
            r_rd <= '0; r_und <= '0;
        end else if (i_step) begin
            r_stage <= n_stage; r_idx <= n_idx; r_hleft <= n_hleft; r_bleft <= n_bleft;
            r_acc <= n_acc; r_id <= n_id; r_shift <= n_shift; r_pleft <= n_pleft;
            r_notes <= n_notes; r_nr0 <= n_nr0; r_nr1 <= n_nr1; r_chan <= n_chan;
            r_pat <= n_pat; r_tempo <= n_tempo; r_res <= n_res; r_ccnt <= n_ccnt;
            r_rd <= n_rd; r_und <= n_und;
        end
    end
endmodule

// ===== rtl/tesp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tesp_out_reg
// Result register with a skid stage that takes one more result while output stalls.
// ----------------------------------------------------------------------------
module tesp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tesp_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output tesp_pkg::t_result  o_data,
    input  logic               i_stall
);
    logic r_valid, r_skid_valid;
    tesp_pkg::t_result r_data, r_skid;

    // ready while the skid slot is empty
    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_valid <= 1'b1; r_data <= r_skid; r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid; r_data <= i_data;
                end
            end else if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1; r_skid <= i_data;
            end
        end
    end
endmodule

// ===== rtl/tagged_event_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tagged_event_stream_parser
// Byte-stream parser for a tagged-event project file, emitting records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  input   | in        | i_valid / o_stall, fields i_byte_in, i_end_of_file
//  result  | out       | o_valid / i_stall, one port per result field
//
// One byte is taken per cycle while o_stall is low; each byte is decoded in a
// single pass and its result is registered in the output register or its skid
// slot. Input stalls only while the skid slot of the result register is full.
// Reset is synchronous. After an error no further results appear until reset.
module tagged_event_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic        o_data_done,
    output logic [15:0] o_pattern_number,
    output logic [15:0] o_rack_channel,
    output logic [31:0] o_note_position,
    output logic [31:0] o_note_duration,
    output logic [6:0]  o_note_pitch,
    output logic [6:0]  o_note_velocity,
    output logic [19:0] o_tempo_milli_bpm,
    output logic [15:0] o_ticks_per_quarter,
    output logic [31:0] o_events_read,
    output logic [31:0] o_events_understood
);
    `include "tagged_event_stream_parser_assert.svh"

    logic ready, step, res_valid;
    tesp_pkg::t_result res, out;
    tesp_pkg::t_stage  stage;

    assign o_stall = !ready;
    assign step = i_valid && ready;

    tesp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(i_byte_in),
        .i_eof(i_end_of_file), .o_res_valid(res_valid), .o_res(res), .o_stage(stage)
    );

    tesp_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(step && res_valid), .i_data(res),
        .o_ready(ready), .o_valid(o_valid), .o_data(out), .i_stall(i_stall)
    );

    assign o_kind = out.kind;
    assign o_data_done = out.done;
    assign o_pattern_number = out.pattern;
    assign o_rack_channel = out.channel;
    assign o_note_position = out.position;
    assign o_note_duration = out.duration;
    assign o_note_pitch = out.pitch;
    assign o_note_velocity = out.velocity;
    assign o_tempo_milli_bpm = out.tempo;
    assign o_ticks_per_quarter = out.tpq;
    assign o_events_read = out.read_cnt;
    assign o_events_understood = out.und_cnt;

    // halted parser never produces another result
    `TESP_ASSERT_NEXT(a_halt_quiet, i_clk, i_rst_n,
        stage == tesp_pkg::ST_HALT, !(step && res_valid))
    // a note never carries a zero duration
    `TESP_ASSERT_IMPL(a_note_dur, i_clk, i_rst_n,
        (o_valid && o_kind == tesp_pkg::K_NOTE) |-> (o_note_duration != 32'd0))
    // once done the parser stays done
    `TESP_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n,
        stage == tesp_pkg::ST_DONE, stage == tesp_pkg::ST_DONE)
endmodule

// ===== tb/sv/tb_tagged_event_stream_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tagged event stream parser testbench
// Builds one project file (header, data prefix, directed and random events,
// then a clean end or an error ending), streams it through the parser with
// random gaps and output stalls, and checks every result transaction against
// a cycle-free model of the parser held in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_tagged_event_stream_parser;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BODY_TARGET = 1600;

    // scoreboard: models the parser byte by byte and holds expected records
    class record_scoreboard;
        tesp_pkg::t_result expected_records[$];
        int      mismatches;
        tesp_pkg::t_stage  stage;
        int unsigned idx, shift;
        bit [31:0] hdr_left, blk_left, acc, rd_cnt, und_cnt;
        bit [7:0]  ev_id;
        bit [34:0] pay_left;
        bit        is_notes;
        bit [63:0] rec0, rec1;
        bit [15:0] cur_ch, cur_pat, tpq, chans;
        bit [19:0] tempo;
        bit [7:0]  hdr_tag[4] = '{8'h46, 8'h4C, 8'h68, 8'h64};
        bit [7:0]  dat_tag[4] = '{8'h46, 8'h4C, 8'h64, 8'h74};

        function new();
            stage = tesp_pkg::ST_HPRE; idx = 0; shift = 0;
            hdr_left = 0; blk_left = 0; acc = 0; rd_cnt = 0; und_cnt = 0;
            ev_id = 0; pay_left = 0; is_notes = 0; rec0 = 0; rec1 = 0;
            cur_ch = 0; cur_pat = 0; tpq = 0; chans = 0; tempo = tesp_pkg::TEMPO_RESET;
            mismatches = 0;
        endfunction

        function void emit(logic [3:0] k, bit done, bit [15:0] ch, bit [31:0] pos,
                           bit [31:0] dur, bit [6:0] pit, bit [6:0] vel);
            tesp_pkg::t_result r;
            r.kind = k; r.done = done; r.pattern = cur_pat; r.channel = ch;
            r.position = pos; r.duration = dur; r.pitch = pit; r.velocity = vel;
            r.tempo = tempo; r.tpq = tpq; r.read_cnt = rd_cnt; r.und_cnt = und_cnt;
            expected_records.insert(expected_records.size(), r);
        endfunction

        function void halt(logic [3:0] code);
            stage = tesp_pkg::ST_HALT;
            emit(code, 0, cur_ch, 0, 0, 0, 0);
        endfunction

        // one accepted input transaction
        function void note_byte(bit [7:0] b, bit eof);
            int unsigned need, o, lim, v;
            int        k;
            bit        complete, understood;
            bit [15:0] ch;
            bit [31:0] pos, dur;
            bit [6:0]  pit, vel;
            bit [63:0] wide;
            k = -1; complete = 0; understood = 0;
            ch = cur_ch; pos = 0; dur = 0; pit = 0; vel = 0;
            wide = {56'd0, b};
            case (stage)
                tesp_pkg::ST_HPRE: begin
                    if (idx < 7 && eof) begin halt(tesp_pkg::K_SHORT); return; end
                    if (idx < 4) begin
                        if (b != hdr_tag[idx]) begin
                            halt(tesp_pkg::K_BAD_MAGIC); return;
                        end
                        if (idx == 0) acc = 0;
                    end else begin
                        acc |= 32'(b) << (8 * (idx - 4));
                    end
                    if (idx == 7) begin
                        hdr_left = acc;
                        if (hdr_left < 6 || eof) begin
                            halt(tesp_pkg::K_BAD_HSIZE); return;
                        end
                        idx = 0;
                        stage = tesp_pkg::ST_HBODY;
                    end else begin
                        idx++;
                    end
                    return;
                end
                tesp_pkg::ST_HBODY: begin
                    hdr_left--;
                    if (idx == 2) chans = {8'd0, b};
                    else if (idx == 3) chans[15:8] = b;
                    else if (idx == 4) tpq = {8'd0, b};
                    else if (idx == 5) tpq[15:8] = b;
                    if (idx < 6) idx++;
                    if (hdr_left == 0) begin
                        if (tpq == 0) begin halt(tesp_pkg::K_ZERO_TPQ); return; end
                        if (eof) begin halt(tesp_pkg::K_NO_DATA); return; end
                        idx = 0;
                        stage = tesp_pkg::ST_DPRE;
                        emit(tesp_pkg::K_HEADER, 0, chans, 0, 0, 0, 0);
                        return;
                    end
                    if (eof) halt(tesp_pkg::K_BAD_HSIZE);
                    return;
                end
                tesp_pkg::ST_DPRE: begin
                    if (idx < 7 && eof) begin halt(tesp_pkg::K_NO_DATA); return; end
                    if (idx < 4) begin
                        if (b != dat_tag[idx]) begin halt(tesp_pkg::K_NO_DATA); return; end
                        if (idx == 0) acc = 0;
                    end else begin
                        acc |= 32'(b) << (8 * (idx - 4));
                    end
                    if (idx == 7) begin
                        blk_left = acc;
                        idx = 0;
                        if (blk_left == 0) begin
                            stage = tesp_pkg::ST_DONE;
                            emit(tesp_pkg::K_END, 1, cur_ch, 0, 0, 0, 0);
                            return;
                        end
                        if (eof) begin halt(tesp_pkg::K_DATA_LONG); return; end
                        stage = tesp_pkg::ST_ID;
                    end else begin
                        idx++;
                    end
                    return;
                end
                tesp_pkg::ST_ID, tesp_pkg::ST_FIXED, tesp_pkg::ST_LEN,
                tesp_pkg::ST_PAYLOAD: ;
                default: return;
            endcase

            if (blk_left > 0) blk_left--;
            if (eof && blk_left > 0) begin halt(tesp_pkg::K_DATA_LONG); return; end

            if (stage == tesp_pkg::ST_ID) begin
                need = b < 64 ? 1 : b < 128 ? 2 : b < 192 ? 4 : 0;
                ev_id = b;
                if (rd_cnt != '1) rd_cnt++;
                if (need != 0) begin
                    if (blk_left < need) begin halt(tesp_pkg::K_TRUNC); return; end
                    acc = 0; idx = 0; pay_left = 35'(need);
                    stage = tesp_pkg::ST_FIXED;
                end else begin
                    if (blk_left == 0) begin halt(tesp_pkg::K_TRUNC); return; end
                    pay_left = 0; shift = 0;
                    stage = tesp_pkg::ST_LEN;
                end
            end else if (stage == tesp_pkg::ST_FIXED) begin
                acc |= 32'(b) << (8 * (idx & 3));
                idx = (idx + 1) & 31;
                pay_left--;
                if (pay_left == 0) begin
                    complete = 1;
                    if (ev_id == tesp_pkg::ID_CHANNEL) begin
                        cur_ch = acc[15:0]; understood = 1; k = tesp_pkg::K_CHANNEL;
                    end else if (ev_id == tesp_pkg::ID_PATTERN) begin
                        cur_pat = acc[15:0]; understood = 1; k = tesp_pkg::K_PATTERN;
                    end else if (ev_id == tesp_pkg::ID_TEMPO_BPM && acc >= 20
                                 && acc <= 999) begin
                        tempo = 20'(acc * 1000); understood = 1; k = tesp_pkg::K_TEMPO;
                    end else if (ev_id == tesp_pkg::ID_TEMPO_MILLI
                                 && acc >= tesp_pkg::TEMPO_MIN
                                 && acc <= tesp_pkg::TEMPO_MAX) begin
                        tempo = acc[19:0]; understood = 1; k = tesp_pkg::K_TEMPO;
                    end
                    ch = cur_ch;
                end
            end else if (stage == tesp_pkg::ST_LEN) begin
                pay_left = 35'({29'd0, pay_left} | ({57'd0, b[6:0]} << (shift & 31)));
                if (b[7]) begin
                    shift += 7;
                    if (shift > 28) begin halt(tesp_pkg::K_LEN_LONG); return; end
                    if (blk_left == 0) begin halt(tesp_pkg::K_TRUNC); return; end
                end else begin
                    if (pay_left > {3'd0, blk_left}) begin
                        halt(tesp_pkg::K_TRUNC); return;
                    end
                    is_notes = 0; idx = 0;
                    if (ev_id == tesp_pkg::ID_NOTES) begin
                        if (pay_left % 24 != 0) k = tesp_pkg::K_REJECT;
                        else is_notes = 1;
                    end
                    if (pay_left == 0) complete = 1;
                    else stage = tesp_pkg::ST_PAYLOAD;
                end
            end else begin
                if (is_notes) begin
                    o = idx;
                    if (o == 0) begin rec0 = 0; rec1 = 0; end
                    if (o < 4) rec0 |= wide << (8 * o);
                    else if (o >= 8 && o < 12) rec0 |= wide << (32 + 8 * (o - 8));
                    else if (o == 6 || o == 7) rec1 |= wide << (8 * (o - 6));
                    else if (o == 12) rec1 |= wide << 16;
                    else if (o == 21) rec1 |= wide << 24;
                    o++;
                    if (o >= 24) begin
                        lim = chans == 0 ? 256 : chans + 1;
                        o = 0;
                        if (rec0[63:32] != 0 && rec1[15:0] < lim) begin
                            k = tesp_pkg::K_NOTE;
                            ch = rec1[15:0];
                            pos = rec0[31:0];
                            dur = rec0[63:32];
                            v = rec1[23:16];
                            pit = v > 127 ? 7'd127 : 7'(v);
                            v = rec1[31:24];
                            vel = v < 1 ? 7'd1 : (v > 127 ? 7'd127 : 7'(v));
                        end
                    end
                    idx = o;
                end
                pay_left--;
                if (pay_left == 0) complete = 1;
            end

            if (complete) begin
                if (ev_id == tesp_pkg::ID_TEXT0 || ev_id == tesp_pkg::ID_TEXT1
                    || ev_id == tesp_pkg::ID_TEXT2 || ev_id == tesp_pkg::ID_TEXT3)
                    understood = 1;
                if (ev_id == tesp_pkg::ID_NOTES && is_notes) understood = 1;
                if (understood && und_cnt != '1) und_cnt++;
                stage = tesp_pkg::ST_ID;
                if (blk_left == 0) begin
                    stage = tesp_pkg::ST_DONE;
                    emit(k < 0 ? tesp_pkg::K_END : 4'(k), 1, ch, pos, dur, pit, vel);
                    return;
                end
            end
            if (k >= 0) emit(4'(k), 0, ch, pos, dur, pit, vel);
        endfunction

        // one accepted result transaction
        function void check_record(tesp_pkg::t_result got);
            tesp_pkg::t_result exp_r;
            if (expected_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d done %0d", got.kind, got.done);
                return;
            end
            exp_r = expected_records.pop_front();
            if (got.kind !== exp_r.kind || got.done !== exp_r.done
                || got.pattern !== exp_r.pattern || got.channel !== exp_r.channel
                || got.position !== exp_r.position || got.duration !== exp_r.duration
                || got.pitch !== exp_r.pitch || got.velocity !== exp_r.velocity
                || got.tempo !== exp_r.tempo || got.tpq !== exp_r.tpq
                || got.read_cnt !== exp_r.read_cnt || got.und_cnt !== exp_r.und_cnt) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: k%0d d%0d pat%0d ch%0d pos%0d dur%0d p%0d v%0d",
                             exp_r.kind, exp_r.done, exp_r.pattern, exp_r.channel,
                             exp_r.position, exp_r.duration, exp_r.pitch, exp_r.velocity);
                    $display("  tempo%0d tpq%0d rd%0d und%0d", exp_r.tempo, exp_r.tpq,
                             exp_r.read_cnt, exp_r.und_cnt);
                    $display("mismatch got: k%0d d%0d pat%0d ch%0d pos%0d dur%0d p%0d v%0d",
                             got.kind, got.done, got.pattern, got.channel,
                             got.position, got.duration, got.pitch, got.velocity);
                    $display("  tempo%0d tpq%0d rd%0d und%0d", got.tempo, got.tpq,
                             got.read_cnt, got.und_cnt);
                end
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, i_stall, i_end_of_file;
    logic [7:0]  i_byte_in;
    logic        o_stall, o_valid, o_data_done;
    logic [3:0]  o_kind;
    logic [15:0] o_pattern_number, o_rack_channel, o_ticks_per_quarter;
    logic [31:0] o_note_position, o_note_duration, o_events_read, o_events_understood;
    logic [6:0]  o_note_pitch, o_note_velocity;
    logic [19:0] o_tempo_milli_bpm;

    tagged_event_stream_parser u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_byte_in(i_byte_in), .i_end_of_file(i_end_of_file),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_data_done(o_data_done),
        .o_pattern_number(o_pattern_number), .o_rack_channel(o_rack_channel),
        .o_note_position(o_note_position), .o_note_duration(o_note_duration),
        .o_note_pitch(o_note_pitch), .o_note_velocity(o_note_velocity),
        .o_tempo_milli_bpm(o_tempo_milli_bpm), .o_ticks_per_quarter(o_ticks_per_quarter),
        .o_events_read(o_events_read), .o_events_understood(o_events_understood)
    );

    record_scoreboard sb = new();
    bit [7:0]  body[$];
    bit [8:0]  file_bytes[$];   // {end_of_file, byte}
    int        chan_limit;
    int        results_seen;
    int        cycles;

    // clock
    initial begin
        i_clk = 0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // event builders
    function void add_byte(bit [7:0] v);
        body.insert(body.size(), v);
    endfunction

    function void put_u16(bit [15:0] v);
        add_byte(v[7:0]); add_byte(v[15:8]);
    endfunction

    function void put_u32(bit [31:0] v);
        put_u16(v[15:0]); put_u16(v[31:16]);
    endfunction

    // base-128 length, optionally with a redundant continuation byte
    function void put_len(int unsigned n, bit pad);
        bit [7:0] c;
        do begin
            c = {1'b0, n[6:0]};
            n = n >> 7;
            if (n != 0 || pad) c[7] = 1;
            add_byte(c);
        end while (n != 0);
        if (pad) add_byte(8'h00);
    endfunction

    function void put_text(bit [7:0] id, int unsigned n, bit pad);
        add_byte(id);
        put_len(n, pad);
        repeat (n) add_byte(8'($urandom));
    endfunction

    // note block; odd_len gives a length that is not a record multiple
    function void put_notes(int nrec, bit odd_len);
        bit [7:0] r[24];
        int       n;
        n = nrec * 24 + (odd_len ? $urandom_range(1, 23) : 0);
        add_byte(tesp_pkg::ID_NOTES);
        put_len(n, $urandom_range(0, 7) == 0);
        if (odd_len) begin
            repeat (n) add_byte(8'($urandom));
            return;
        end
        repeat (nrec) begin
            foreach (r[j]) r[j] = 8'($urandom);
            if ($urandom_range(0, 3) != 0) {r[7], r[6]} = 16'($urandom_range(0, chan_limit + 1));
            if ($urandom_range(0, 9) == 0) {r[11], r[10], r[9], r[8]} = 0;
            if ($urandom_range(0, 5) == 0) r[21] = 0;
            foreach (r[j]) add_byte(r[j]);
        end
    endfunction

    function void put_random_event();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) put_notes($urandom_range(1, 4), 0);
        else if (sel < 35) put_notes($urandom_range(0, 2), 1);
        else if (sel < 43) begin
            add_byte(tesp_pkg::ID_CHANNEL);
            put_u16($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20)));
        end else if (sel < 50) begin
            add_byte(tesp_pkg::ID_PATTERN); put_u16(16'($urandom));
        end else if (sel < 56) begin
            add_byte(tesp_pkg::ID_TEMPO_BPM); put_u16(16'($urandom_range(0, 1100)));
        end else if (sel < 62) begin
            add_byte(tesp_pkg::ID_TEMPO_MILLI); put_u32($urandom_range(0, 1100000));
        end else if (sel < 68) begin
            add_byte(8'($urandom_range(0, 63))); add_byte(8'($urandom));
        end else if (sel < 73) begin
            add_byte(8'($urandom_range(64, 127))); put_u16(16'($urandom));
        end else if (sel < 78) begin
            add_byte(8'($urandom_range(128, 191))); put_u32($urandom);
        end else if (sel < 90) begin
            case ($urandom_range(0, 3))
                0: sel = tesp_pkg::ID_TEXT0;
                1: sel = tesp_pkg::ID_TEXT1;
                2: sel = tesp_pkg::ID_TEXT2;
                default: sel = tesp_pkg::ID_TEXT3;
            endcase
            put_text(8'(sel), $urandom_range(0, 12), $urandom_range(0, 4) == 0);
        end else begin
            put_text(8'($urandom_range(192, 255)), $urandom_range(0, 20),
                     $urandom_range(0, 4) == 0);
        end
    endfunction

    function void push_file(bit [7:0] b);
        file_bytes.insert(file_bytes.size(), {1'b0, b});
    endfunction

    // the whole file: header, data prefix, events and the chosen ending
    function void build_file();
        int          hsize, ending;
        bit [15:0]   chans;
        bit [31:0]   dsize;
        chans = 16'($urandom_range(0, 12));
        chan_limit = chans == 0 ? 256 : chans + 1;
        // directed events: field extremes, every event kind and special case
        add_byte(tesp_pkg::ID_CHANNEL); put_u16(16'hFFFF);
        add_byte(tesp_pkg::ID_CHANNEL); put_u16(0);
        add_byte(tesp_pkg::ID_PATTERN); put_u16(16'hFFFF);
        add_byte(tesp_pkg::ID_TEMPO_BPM); put_u16(19);
        add_byte(tesp_pkg::ID_TEMPO_BPM); put_u16(20);
        add_byte(tesp_pkg::ID_TEMPO_BPM); put_u16(1000);
        add_byte(tesp_pkg::ID_TEMPO_BPM); put_u16(999);
        add_byte(tesp_pkg::ID_TEMPO_MILLI); put_u32(19999);
        add_byte(tesp_pkg::ID_TEMPO_MILLI); put_u32(999001);
        add_byte(tesp_pkg::ID_TEMPO_MILLI); put_u32(tesp_pkg::TEMPO_MIN);
        add_byte(tesp_pkg::ID_TEMPO_MILLI); put_u32(tesp_pkg::TEMPO_MAX);
        add_byte(8'd0); add_byte(8'hFF);
        add_byte(8'd63); add_byte(8'h00);
        add_byte(8'd127); put_u16(16'hFFFF);
        add_byte(8'd128); put_u32(0);
        add_byte(8'd191); put_u32(32'hFFFF_FFFF);
        put_text(tesp_pkg::ID_TEXT0, 0, 0);
        put_text(tesp_pkg::ID_TEXT1, 3, 1);
        put_text(tesp_pkg::ID_TEXT2, 1, 0);
        put_text(tesp_pkg::ID_TEXT3, 2, 0);
        put_text(8'd255, 130, 0);
        put_notes(0, 0);
        put_notes(3, 1);
        // notes: zero duration, out-of-range channel, clamped pitch and velocity
        add_byte(tesp_pkg::ID_NOTES); put_len(72, 0);
        put_u32(32'hFFFF_FFFF); put_u16(0); put_u16(0); put_u32(0);
        repeat (12) add_byte(8'h11);
        put_u32(0); put_u16(0); put_u16(16'(chan_limit)); put_u32(5);
        repeat (12) add_byte(8'h22);
        put_u32(0); put_u16(16'hFFFF); put_u16(16'(chan_limit - 1)); put_u32(32'hFFFF_FFFF);
        add_byte(8'hFF); repeat (8) add_byte(8'h00);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
        while (body.size() < BODY_TARGET) put_random_event();

        ending = $urandom_range(0, 2);
        dsize = body.size();
        if (ending == 1) begin
            // length that runs past five bytes
            add_byte(8'd200);
            repeat (5) add_byte(8'h80);
            dsize = body.size() + 10;
        end else if (ending == 2) begin
            dsize = body.size() + 50;
        end

        hsize = $urandom_range(6, 9);
        push_file(8'h46); push_file(8'h4C); push_file(8'h68); push_file(8'h64);
        for (int j = 0; j < 4; j++) push_file(8'(hsize >> (8 * j)));
        push_file(8'($urandom)); push_file(8'($urandom));
        push_file(chans[7:0]); push_file(chans[15:8]);
        push_file(8'($urandom_range(1, 255))); push_file(8'($urandom));
        repeat (hsize - 6) push_file(8'($urandom));
        push_file(8'h46); push_file(8'h4C); push_file(8'h64); push_file(8'h74);
        for (int j = 0; j < 4; j++) push_file(dsize[8 * j +: 8]);
        foreach (body[j]) push_file(body[j]);
        if (ending != 2) repeat (3) push_file(8'($urandom));
        file_bytes[file_bytes.size() - 1][8] = 1'b1;
    endfunction

    // sender: random gaps, one stretch without gaps, one drain pause
    task automatic send_file();
        int gap;
        foreach (file_bytes[j]) begin
            if (j == 900) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.expected_records.size() != 0) @(posedge i_clk);
            end
            gap = (j >= 300 && j < 500) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid       <= 1'b1;
            i_byte_in     <= file_bytes[j][7:0];
            i_end_of_file <= file_bytes[j][8];
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            sb.note_byte(file_bytes[j][7:0], file_bytes[j][8]);
        end
        i_valid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off, a stretch with none
    initial begin
        int hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (results_seen == 30) hold = 300;
            else if (results_seen >= 10 && results_seen < 25) hold = 0;
            else hold = $urandom_range(0, 4);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            results_seen++;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        tesp_pkg::t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_kind, o_data_done, o_pattern_number, o_rack_channel,
                    o_note_position, o_note_duration, o_note_pitch, o_note_velocity,
                    o_tempo_milli_bpm, o_ticks_per_quarter, o_events_read,
                    o_events_understood};
            sb.check_record(got);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_byte_in     = 8'd0;
        i_end_of_file = 1'b0;
        build_file();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_file();
        while (sb.expected_records.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
